// ===== design/bci_pkg.sv =====
// shared types, curve tables and constants for the battery curve interpolator
`timescale 1ns / 1ps
package bci_pkg;

   localparam int CURVE_POINTS = 13;
   localparam int IDX_W = $clog2(CURVE_POINTS);
   localparam int MV_W = 16;
   localparam int PCT_W = 8;
   localparam int ANS_W = 32;
   localparam int NUM_W = 48;
   localparam int DEN_W = 16;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CURVE_POINTS - 1);

   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      8'd0, 8'd2, 8'd5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 8'd100
   };
   localparam logic [MV_W-1:0] DIS_MV [CURVE_POINTS] = '{
      16'd3300, 16'd3490, 16'd3615, 16'd3655, 16'd3700, 16'd3735, 16'd3760,
      16'd3800, 16'd3855, 16'd3935, 16'd4025, 16'd4120, 16'd4230
   };
   localparam logic [MV_W-1:0] CHG_MV [CURVE_POINTS] = '{
      16'd3550, 16'd3570, 16'd3600, 16'd3645, 16'd3730, 16'd3800, 16'd3860,
      16'd3915, 16'd3970, 16'd4030, 16'd4095, 16'd4175, 16'd4260
   };

   localparam logic [ANS_W-1:0] SCALE_RESET = 32'd42949673;
   localparam logic [MV_W-1:0] FULL_MV_RESET = 16'd4230;
   localparam logic [MV_W-1:0] COMP_RESET = 16'd0;

   typedef enum logic [1:0] {
      REG_SCALE   = 2'd0,
      REG_FULL_MV = 2'd1,
      REG_COMP    = 2'd2,
      REG_NONE    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_SEARCH,
      ST_PREP_BASE,
      ST_PREP_SCALE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ANS_W-1:0] scale_factor;
      logic [MV_W-1:0]  full_voltage_mv;
      logic [MV_W-1:0]  compensation_mv;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numerator;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

   // curve point voltage; discharge top is held at least one above the point below
   function automatic logic [MV_W-1:0] point_mv(logic chg, logic [IDX_W-1:0] idx,
                                                logic [MV_W-1:0] full_mv);
      logic [MV_W-1:0] floor_mv;
      floor_mv = DIS_MV[CURVE_POINTS-2] + 16'd1;
      if (chg) begin
         return CHG_MV[idx];
      end else if (idx == IDX_TOP) begin
         return (full_mv < floor_mv) ? floor_mv : full_mv;
      end else begin
         return DIS_MV[idx];
      end
   endfunction

endpackage

// ===== design/battery_curve_interpolator.sv =====
// battery voltage / charge curve interpolator, top level with sequencer
//
//   channel  ports                    direction  word
//   req      req_valid/req_ready      in         func, sample_value, charging
//   rsp      rsp_valid/rsp_ready      out        answer
//   csr      psel/penable/pwrite ...  in/out     apb, registers at 0x0, 0x4, 0x8
//
// an item runs through the clamp step and, unless clamped at an end, the downward segment
// search, two prep steps and the multiply on the shared 32x16 multiplier, then the divider.
// one item at a time; req_ready is high only while the sequencer is idle.
// a finished word sits in the output register, so the next item is taken while it waits.
// reset is synchronous and restores the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module battery_curve_interpolator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [bci_pkg::MV_W-1:0]    req_sample_value,
   input  logic                        req_charging,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bci_pkg::ANS_W-1:0]   rsp_answer,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bci_pkg::ADDR_W-1:0]  paddr,
   input  logic [bci_pkg::DATA_W-1:0]  pwdata,
   output logic [bci_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import bci_pkg::*;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type        state_ff, state_in;
   logic             func_ff, func_in;
   logic             chg_ff, chg_in;
   logic [MV_W-1:0]  sample_ff, sample_in;
   logic [MV_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [ANS_W-1:0] base_ff, base_in;
   logic [ANS_W-1:0] scaled_ff, scaled_in;
   logic [MV_W-1:0]  oper_ff, oper_in;
   logic [DEN_W-1:0] divisor_ff, divisor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ANS_W-1:0] result_ff, result_in;
   logic [ANS_W-1:0] answer_ff, answer_in;

   logic [IDX_W-1:0]   idx_lo, idx_hi;
   logic [MV_W-1:0]    pt_lo, pt_hi;
   logic [PCT_W-1:0]   pct_lo, pct_hi;
   logic [ANS_W-1:0]   mul_a;
   logic [MV_W-1:0]    mul_b;
   logic [NUM_W-1:0]   prod;
   logic signed [MV_W+1:0] mv_s;
   logic [MV_W-1:0]    cmp_val;

   bci_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bci_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // the one multiplier, shared by the clamp, prep and multiply steps
   assign prod = mul_a * mul_b;

   always_comb begin
      idx_lo = (state_ff == ST_CLAMP) ? '0 : idx_ff;
      idx_hi = (state_ff == ST_CLAMP) ? IDX_TOP : IDX_W'(idx_ff + 1'b1);
      pt_lo = point_mv(chg_ff, idx_lo, cfg.full_voltage_mv);
      pt_hi = point_mv(chg_ff, idx_hi, cfg.full_voltage_mv);
      pct_lo = CURVE_PCT[idx_lo];
      pct_hi = CURVE_PCT[idx_hi];
      mv_s = $signed({2'b00, sample_ff})
           + $signed({{2{cfg.compensation_mv[MV_W-1]}}, cfg.compensation_mv});
      cmp_val = func_ff ? {{(MV_W-PCT_W){1'b0}}, pct_lo} : pt_lo;

      state_in = state_ff;
      func_in = func_ff;
      chg_in = chg_ff;
      sample_in = sample_ff;
      key_in = key_ff;
      idx_in = idx_ff;
      base_in = base_ff;
      scaled_in = scaled_ff;
      oper_in = oper_ff;
      divisor_in = divisor_ff;
      result_in = result_ff;
      answer_in = answer_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a = cfg.scale_factor;
      mul_b = '0;
      div_req.start = 1'b0;
      div_req.numerator = prod;
      div_req.divisor = divisor_ff;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_func;
               chg_in = req_charging;
               sample_in = req_sample_value;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            mul_b = MV_W'(CURVE_PCT[CURVE_POINTS-1]);
            idx_in = IDX_W'(CURVE_POINTS - 2);
            if (func_ff) begin
               key_in = sample_ff;
               if (sample_ff > MV_W'(CURVE_PCT[CURVE_POINTS-1])) begin
                  result_in = {{(ANS_W-MV_W){1'b0}}, pt_hi};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end else begin
               key_in = mv_s[MV_W-1:0];
               if (mv_s <= $signed({2'b00, pt_lo})) begin
                  result_in = '0;
                  state_in = ST_DONE;
               end else if (mv_s >= $signed({2'b00, pt_hi})) begin
                  result_in = prod[ANS_W-1:0];
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (idx_ff != '0 && key_ff < cmp_val) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = ST_PREP_BASE;
            end
         end
         ST_PREP_BASE: begin
            mul_b = {{(MV_W-PCT_W){1'b0}}, pct_lo};
            if (func_ff) begin
               base_in = {{(ANS_W-MV_W){1'b0}}, pt_lo};
               divisor_in = {{(DEN_W-PCT_W){1'b0}}, pct_hi - pct_lo};
               oper_in = key_ff - {{(MV_W-PCT_W){1'b0}}, pct_lo};
               scaled_in = {{(ANS_W-MV_W){1'b0}}, pt_hi - pt_lo};
            end else begin
               base_in = prod[ANS_W-1:0];
               divisor_in = pt_hi - pt_lo;
               oper_in = key_ff - pt_lo;
            end
            state_in = ST_PREP_SCALE;
         end
         ST_PREP_SCALE: begin
            mul_b = {{(MV_W-PCT_W){1'b0}}, pct_hi - pct_lo};
            if (!func_ff) begin
               scaled_in = prod[ANS_W-1:0];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_a = scaled_ff;
            mul_b = oper_ff;
            div_req.start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               result_in = div_rsp.quotient[ANS_W-1:0] + base_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               answer_in = result_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      chg_ff <= chg_in;
      sample_ff <= sample_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      base_ff <= base_in;
      scaled_ff <= scaled_in;
      oper_ff <= oper_in;
      divisor_ff <= divisor_in;
      result_ff <= result_in;
      answer_ff <= answer_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_answer = answer_ff;

   // the divider only ever finishes while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   // segments always have a nonzero width, so the divisor is never zero
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> divisor_ff != '0)
      else $error("zero divisor handed to divider");

   // search index never leaves the lower end of a valid segment
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> idx_ff <= IDX_W'(CURVE_POINTS - 2))
      else $error("segment index out of range");

   // an accepted word always starts at the clamp step
   a_accept_to_clamp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CLAMP)
      else $error("accepted word did not start the sequence");

   // a waiting result is not overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(answer_ff))
      else $error("pending result lost");

endmodule

// ===== design/bci_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bci_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bci_pkg::div_req_type div_req,
   output bci_pkg::div_rsp_type div_rsp
);
   import bci_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff = trial - {1'b0, den_ff};
      fits = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         count_in = CNT_W'(NUM_W - 1);
         quo_in = div_req.numerator;
         rem_in = '0;
         den_in = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits back in DEN_W bits
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== design/bci_csr.sv =====
// apb register file for scale factor, full voltage and compensation
`timescale 1ns / 1ps
module bci_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bci_pkg::ADDR_W-1:0]  paddr,
   input  logic [bci_pkg::DATA_W-1:0]  pwdata,
   output logic [bci_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output bci_pkg::cfg_type            cfg
);
   import bci_pkg::*;

   logic [ANS_W-1:0] scale_ff, scale_in;
   logic [MV_W-1:0]  full_ff, full_in;
   logic [MV_W-1:0]  comp_ff, comp_in;

   reg_index_type reg_sel;
   logic          wr_en;

   always_comb begin
      reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);
      wr_en = psel && penable && pwrite;
      scale_in = scale_ff;
      full_in = full_ff;
      comp_in = comp_ff;
      prdata = '0;
      unique case (reg_sel)
         REG_SCALE: begin
            prdata = scale_ff;
            if (wr_en) scale_in = pwdata;
         end
         REG_FULL_MV: begin
            prdata = {{(DATA_W-MV_W){1'b0}}, full_ff};
            if (wr_en) full_in = pwdata[MV_W-1:0];
         end
         REG_COMP: begin
            prdata = {{(DATA_W-MV_W){1'b0}}, comp_ff};
            if (wr_en) comp_in = pwdata[MV_W-1:0];
         end
         REG_NONE: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         full_ff <= FULL_MV_RESET;
         comp_ff <= COMP_RESET;
      end else begin
         scale_ff <= scale_in;
         full_ff <= full_in;
         comp_ff <= comp_in;
      end
   end

   assign pready = 1'b1;
   assign cfg.scale_factor = scale_ff;
   assign cfg.full_voltage_mv = full_ff;
   assign cfg.compensation_mv = comp_ff;

endmodule
